// ===== sv/lcalc_pkg.sv =====
// Shared types, widths and constant tables for the lux calculation block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package lcalc_pkg;

   localparam int CNT_W    = 16;          // channel count width
   localparam int CTRL_W   = 8;           // control word width
   localparam int REG_W    = 16;          // widest register
   localparam int IDX_W    = 3;           // register index width
   localparam int PROD_W   = 32;          // 16x16 product width
   localparam int LUX_W    = 32;
   localparam int TG_W     = 23;          // time * gain, max 600 * 9876
   localparam int NUM_W    = 39;          // time * gain * scale
   localparam int DEN_W    = 32;          // atten * device factor
   localparam int CPL_W    = NUM_W;       // counts per lux
   localparam int REM_W    = CPL_W;       // divider remainder
   localparam int STEP_W   = 6;           // cpl divide step counter
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int QCNT_W   = 3;

   localparam logic [CTRL_W-1:0] CTRL_RST  = 8'd16;
   localparam logic [REG_W-1:0]  ATTEN_RST = 16'd1;
   localparam logic [REG_W-1:0]  SCALE_RST = 16'd1000;
   localparam logic [REG_W-1:0]  DEVF_RST  = 16'd408;
   localparam logic [REG_W-1:0]  COEFB_RST = 16'd1640;
   localparam logic [REG_W-1:0]  COEFC_RST = 16'd590;
   localparam logic [REG_W-1:0]  COEFD_RST = 16'd860;

   typedef enum logic [IDX_W-1:0] {
      REG_CONTROL = 3'd0,
      REG_ATTEN   = 3'd1,
      REG_SCALE   = 3'd2,
      REG_DEVF    = 3'd3,
      REG_COEF_B  = 3'd4,
      REG_COEF_C  = 3'd5,
      REG_COEF_D  = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [CTRL_W-1:0] control;
      logic [REG_W-1:0]  atten;
      logic [REG_W-1:0]  scale;
      logic [REG_W-1:0]  devf;
      logic [REG_W-1:0]  coef_b;
      logic [REG_W-1:0]  coef_c;
      logic [REG_W-1:0]  coef_d;
   } cfg_type;

   // Integration time (ms) times analog gain, by time code and gain code.
   function automatic logic [TG_W-1:0] time_gain(input logic [2:0] tcode,
                                                 input logic [1:0] gcode);
      logic [9:0]  t;
      logic [13:0] g;
      case (tcode)
         3'd1:    t = 10'd200;
         3'd2:    t = 10'd300;
         3'd3:    t = 10'd400;
         3'd4:    t = 10'd500;
         3'd5:    t = 10'd600;
         default: t = 10'd100;
      endcase
      case (gcode)
         2'd1:    g = 14'd25;
         2'd2:    g = 14'd428;
         2'd3:    g = 14'd9876;
         default: g = 14'd1;
      endcase
      return TG_W'(t * g);
   endfunction

endpackage

// ===== sv/lcalc_req_if.sv =====
// Input channel: valid/ready plus one pair of channel counts.
// Depends on lcalc_pkg.
`timescale 1ns / 1ps

interface lcalc_req_if;
   logic                         valid;
   logic                         ready;
   logic [lcalc_pkg::CNT_W-1:0]  full_count;
   logic [lcalc_pkg::CNT_W-1:0]  ir_count;

   modport source (output valid, full_count, ir_count, input ready);
   modport sink   (input valid, full_count, ir_count, output ready);
endinterface

// ===== sv/lcalc_rsp_if.sv =====
// Result channel: valid/ready plus lux and calibration flag.
// Depends on lcalc_pkg.
`timescale 1ns / 1ps

interface lcalc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lcalc_pkg::LUX_W-1:0]  lux;
   logic                         no_calibration;

   modport source (output valid, lux, no_calibration, input ready);
   modport sink   (input valid, lux, no_calibration, output ready);
endinterface

// ===== sv/light_sensor_lux_calc_unit.sv =====
// Top level of the two-channel lux calculation: registers, cpl unit,
// front end, queue and divider pipeline. Depends on lcalc_pkg, the two
// channel interfaces and the lcalc_* modules.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+------------------------------------------
//  req_bus  | in        | full_count[15:0], ir_count[15:0]
//  rsp_bus  | out       | lux[31:0], no_calibration
//  csr_*    | in        | write enable, index[2:0], data[15:0]
//
//  One beat per cycle sustained while rsp is ready and cpl is not being
//  recomputed; a beat passes one product stage, the queue and 32 divider
//  stages (one quotient bit each). After reset the counts-per-lux unit runs
//  one multiply step and a 39-step serial divide with req_bus.ready low. A
//  register write holds ready low in the write cycle, the restart cycle and
//  the whole recompute. Reset is synchronous, active high.
//  rsp back-pressure freezes the divider; the 4-entry queue lets the front
//  end keep accepting until it fills.

module light_sensor_lux_calc_unit (
   input  logic                          clock,
   input  logic                          reset,
   lcalc_req_if.sink                     req_bus,
   lcalc_rsp_if.source                   rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [lcalc_pkg::IDX_W-1:0]   csr_index,
   input  logic [lcalc_pkg::REG_W-1:0]   csr_wr_data
);
   lcalc_pkg::cfg_type             cfg_ff;
   logic [lcalc_pkg::CPL_W-1:0]    cpl;
   logic                           cpl_zero;
   logic                           cpl_busy;
   logic                           front_ready;
   logic                           q_full, q_not_empty, push, pop;
   logic [lcalc_pkg::LUX_W-1:0]    push_num, q_head, quotient;

   // Register file. Index 7 writes nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control <= lcalc_pkg::CTRL_RST;
         cfg_ff.atten   <= lcalc_pkg::ATTEN_RST;
         cfg_ff.scale   <= lcalc_pkg::SCALE_RST;
         cfg_ff.devf    <= lcalc_pkg::DEVF_RST;
         cfg_ff.coef_b  <= lcalc_pkg::COEFB_RST;
         cfg_ff.coef_c  <= lcalc_pkg::COEFC_RST;
         cfg_ff.coef_d  <= lcalc_pkg::COEFD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            lcalc_pkg::REG_CONTROL: cfg_ff.control <= csr_wr_data[lcalc_pkg::CTRL_W-1:0];
            lcalc_pkg::REG_ATTEN:   cfg_ff.atten   <= csr_wr_data;
            lcalc_pkg::REG_SCALE:   cfg_ff.scale   <= csr_wr_data;
            lcalc_pkg::REG_DEVF:    cfg_ff.devf    <= csr_wr_data;
            lcalc_pkg::REG_COEF_B:  cfg_ff.coef_b  <= csr_wr_data;
            lcalc_pkg::REG_COEF_C:  cfg_ff.coef_c  <= csr_wr_data;
            lcalc_pkg::REG_COEF_D:  cfg_ff.coef_d  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Any write sets restart_ff, which sends the cpl unit back to its multiply step; the recompute uses the new values.
   logic restart_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= csr_wr_en;
      end
   end

   lcalc_cpl u_cpl (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart_ff),
      .cfg      (cfg_ff),
      .cpl      (cpl),
      .cpl_zero (cpl_zero),
      .busy     (cpl_busy)
   );

   // Hold off input while cpl is stale (busy, or a write just landed).
   assign req_bus.ready = front_ready && !cpl_busy && !restart_ff && !csr_wr_en;

   lcalc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_bus.valid && req_bus.ready),
      .in_ready   (front_ready),
      .full_count (req_bus.full_count),
      .ir_count   (req_bus.ir_count),
      .q_full     (q_full),
      .push       (push),
      .push_num   (push_num)
   );

   lcalc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_num),
      .pop       (pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   lcalc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cpl         (cpl),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .quotient    (quotient)
   );

   // Zero cpl: divider output is meaningless, force lux to zero and flag it.
   assign rsp_bus.lux            = cpl_zero ? '0 : quotient;
   assign rsp_bus.no_calibration = cpl_zero;
endmodule

// ===== sv/lcalc_cpl.sv =====
// Counts-per-lux unit: one multiply step then a bit-serial restoring divide.
// Depends on lcalc_pkg.
`timescale 1ns / 1ps

module lcalc_cpl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  lcalc_pkg::cfg_type            cfg,
   output logic [lcalc_pkg::CPL_W-1:0]   cpl,
   output logic                          cpl_zero,
   output logic                          busy
);
   typedef enum logic [2:0] {
      ST_MUL  = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [lcalc_pkg::NUM_W-1:0]        num_ff, num_in;
   logic [lcalc_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [lcalc_pkg::DEN_W:0]          rem_ff, rem_in;
   logic [lcalc_pkg::CPL_W-1:0]        quo_ff, quo_in;
   logic [lcalc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [lcalc_pkg::REG_W-1:0]        atten_eff;
   logic [lcalc_pkg::DEN_W+1:0]        shifted;

   assign atten_eff = (cfg.atten == '0) ? lcalc_pkg::REG_W'(1) : cfg.atten;
   assign shifted   = {rem_ff, num_ff[lcalc_pkg::NUM_W-1]};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_MUL: begin
            num_in  = lcalc_pkg::NUM_W'(lcalc_pkg::time_gain(cfg.control[2:0],
                                                             cfg.control[5:4]) * cfg.scale);
            den_in  = atten_eff * cfg.devf;
            rem_in  = '0;
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (shifted >= {2'b00, den_ff}) begin
               rem_in = (lcalc_pkg::DEN_W+1)'(shifted - {2'b00, den_ff});
               quo_in = {quo_ff[lcalc_pkg::CPL_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[lcalc_pkg::DEN_W:0];
               quo_in = {quo_ff[lcalc_pkg::CPL_W-2:0], 1'b0};
            end
            num_in  = num_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == lcalc_pkg::STEP_W'(lcalc_pkg::NUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_DONE;
         default: state_in = ST_MUL;
      endcase
      if (restart) begin
         state_in = ST_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MUL;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Zero denominator gives a zero quotient by definition.
   assign cpl      = (den_ff == '0) ? '0 : quo_ff;
   assign cpl_zero = (cpl == '0);
   assign busy     = (state_ff != ST_DONE);
endmodule

// ===== sv/lcalc_front.sv =====
// Front end: channel products, clamped differences, larger of the two.
// Depends on lcalc_pkg.
`timescale 1ns / 1ps

module lcalc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  lcalc_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [lcalc_pkg::CNT_W-1:0]   full_count,
   input  logic [lcalc_pkg::CNT_W-1:0]   ir_count,
   input  logic                          q_full,
   output logic                          push,
   output logic [lcalc_pkg::LUX_W-1:0]   push_num
);
   logic                              vld_ff;
   logic [lcalc_pkg::PROD_W-1:0]      p1_ff, q1_ff, p2_ff, q2_ff;
   logic [lcalc_pkg::PROD_W-1:0]      d1, d2;
   logic                              adv;

   assign adv      = !vld_ff || !q_full;
   assign in_ready = adv;
   assign push     = vld_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
      if (adv) begin
         p1_ff <= full_count * cfg.scale;
         q1_ff <= ir_count * cfg.coef_b;
         p2_ff <= full_count * cfg.coef_c;
         q2_ff <= ir_count * cfg.coef_d;
      end
   end

   // Same positive divisor for both estimates, so the max can be taken first.
   assign d1       = (p1_ff > q1_ff) ? p1_ff - q1_ff : '0;
   assign d2       = (p2_ff > q2_ff) ? p2_ff - q2_ff : '0;
   assign push_num = (d1 > d2) ? d1 : d2;
endmodule

// ===== sv/lcalc_queue.sv =====
// Short FIFO between front end and divider pipeline.
// Depends on lcalc_pkg.
`timescale 1ns / 1ps

module lcalc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [lcalc_pkg::LUX_W-1:0]   push_data,
   input  logic                          pop,
   output logic [lcalc_pkg::LUX_W-1:0]   head,
   output logic                          not_empty,
   output logic                          full
);
   logic [lcalc_pkg::LUX_W-1:0]   mem_ff [lcalc_pkg::QDEPTH];
   logic [lcalc_pkg::QPTR_W-1:0]  wr_ff, rd_ff;
   logic [lcalc_pkg::QCNT_W-1:0]  cnt_ff;

   assign head      = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == lcalc_pkg::QCNT_W'(lcalc_pkg::QDEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== sv/lcalc_back.sv =====
// Back end: 32-stage restoring divider, one quotient bit per stage.
// Depends on lcalc_pkg.
`timescale 1ns / 1ps

module lcalc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lcalc_pkg::CPL_W-1:0]   cpl,
   input  logic                          q_not_empty,
   input  logic [lcalc_pkg::LUX_W-1:0]   q_head,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [lcalc_pkg::LUX_W-1:0]   quotient
);
   localparam int NST = lcalc_pkg::LUX_W;

   logic                              vld_ff [NST];
   logic [lcalc_pkg::REM_W-1:0]       rem_ff [NST];
   logic [lcalc_pkg::LUX_W-1:0]       num_ff [NST];
   logic [lcalc_pkg::LUX_W-1:0]       quo_ff [NST];
   logic [lcalc_pkg::REM_W-1:0]       rem_in [NST];
   logic [lcalc_pkg::LUX_W-1:0]       num_in [NST];
   logic [lcalc_pkg::LUX_W-1:0]       quo_in [NST];
   logic                              adv;

   assign adv       = !vld_ff[NST-1] || out_ready;
   assign pop       = adv && q_not_empty;
   assign out_valid = vld_ff[NST-1];
   assign quotient  = quo_ff[NST-1];

   always_comb begin
      logic [lcalc_pkg::REM_W-1:0]  r;
      logic [lcalc_pkg::LUX_W-1:0]  n;
      logic [lcalc_pkg::LUX_W-1:0]  q;
      logic [lcalc_pkg::REM_W:0]    sh;
      for (int k = 0; k < NST; k++) begin
         if (k == 0) begin
            r = '0;
            n = q_head;
            q = '0;
         end else begin
            r = rem_ff[k-1];
            n = num_ff[k-1];
            q = quo_ff[k-1];
         end
         sh = {r, n[lcalc_pkg::LUX_W-1]};
         if (sh >= {1'b0, cpl}) begin
            rem_in[k] = lcalc_pkg::REM_W'(sh - {1'b0, cpl});
            quo_in[k] = {q[lcalc_pkg::LUX_W-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[lcalc_pkg::REM_W-1:0];
            quo_in[k] = {q[lcalc_pkg::LUX_W-2:0], 1'b0};
         end
         num_in[k] = n << 1;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= (k == 0) ? q_not_empty : vld_ff[(k == 0) ? 0 : k-1];
         end
         if (adv) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end
endmodule

// ===== sim/light_sensor_lux_calc_unit_tb.sv =====
// Self-checking bench for the two-channel lux calculation unit: random and
// directed count pairs over several register settings, scoreboard compare.
// Depends on lcalc_pkg, lcalc_req_if, lcalc_rsp_if and the unit's RTL.
`timescale 1ns / 1ps

module light_sensor_lux_calc_unit_tb;

   typedef struct {
      logic [lcalc_pkg::LUX_W-1:0] lux;
      logic                        no_cal;
   } lux_beat_type;

   // Scoreboard: keeps a copy of the registers and the expected beats.
   class lux_scoreboard_type;
      logic [lcalc_pkg::CTRL_W-1:0] ctrl;
      logic [lcalc_pkg::REG_W-1:0]  atten, scale, devf, cb, cc, cd;
      lux_beat_type                 pending[$];
      int                           errors, checked, uncal;

      function new();
         ctrl = lcalc_pkg::CTRL_RST; atten = lcalc_pkg::ATTEN_RST;
         scale = lcalc_pkg::SCALE_RST; devf = lcalc_pkg::DEVF_RST;
         cb = lcalc_pkg::COEFB_RST; cc = lcalc_pkg::COEFC_RST; cd = lcalc_pkg::COEFD_RST;
      endfunction

      function void set_reg(lcalc_pkg::reg_idx_type idx, logic [lcalc_pkg::REG_W-1:0] v);
         case (idx)
            lcalc_pkg::REG_CONTROL: ctrl  = v[lcalc_pkg::CTRL_W-1:0];
            lcalc_pkg::REG_ATTEN:   atten = v;
            lcalc_pkg::REG_SCALE:   scale = v;
            lcalc_pkg::REG_DEVF:    devf  = v;
            lcalc_pkg::REG_COEF_B:  cb    = v;
            lcalc_pkg::REG_COEF_C:  cc    = v;
            lcalc_pkg::REG_COEF_D:  cd    = v;
            default: ;
         endcase
      endfunction

      // Expected lux for one accepted pair of counts.
      function void note_counts(logic [lcalc_pkg::CNT_W-1:0] full,
                                logic [lcalc_pkg::CNT_W-1:0] ir);
         logic [63:0]  t, g, a, den, num, cpl, p1, q1, p2, q2, e1, e2;
         lux_beat_type exp_beat;
         case (ctrl[2:0])
            3'd1: t = 64'd200; 3'd2: t = 64'd300; 3'd3: t = 64'd400;
            3'd4: t = 64'd500; 3'd5: t = 64'd600;
            default: t = 64'd100;        // codes 6, 7 fall back to 100 ms
         endcase
         case (ctrl[5:4])
            2'd1: g = 64'd25; 2'd2: g = 64'd428; 2'd3: g = 64'd9876;
            default: g = 64'd1;
         endcase
         a   = (atten == '0) ? 64'd1 : 64'(atten);
         den = a * 64'(devf);
         num = t * g * 64'(scale);
         cpl = (den == 64'd0) ? 64'd0 : num / den;
         if (cpl == 64'd0) begin
            exp_beat.lux = '0; exp_beat.no_cal = 1'b1;
         end else begin
            p1 = 64'(full) * 64'(scale); q1 = 64'(cb) * 64'(ir);
            p2 = 64'(cc) * 64'(full);    q2 = 64'(cd) * 64'(ir);
            e1 = (p1 > q1) ? (p1 - q1) / cpl : 64'd0;
            e2 = (p2 > q2) ? (p2 - q2) / cpl : 64'd0;
            exp_beat.lux = (e1 > e2) ? e1[31:0] : e2[31:0];
            exp_beat.no_cal = 1'b0;
         end
         pending.push_back(exp_beat);
      endfunction

      function void check_lux(logic [lcalc_pkg::LUX_W-1:0] lux, logic no_cal);
         lux_beat_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat lux=%0d no_calibration=%0b", lux, no_cal);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (no_cal) uncal++;
         if (lux !== e.lux) begin
            $error("lux: expected %0d, got %0d", e.lux, lux);
            errors++;
         end
         if (no_cal !== e.no_cal) begin
            $error("no_calibration: expected %0b, got %0b", e.no_cal, no_cal);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG = 20000;
   localparam int LATENCY  = 34;

   logic clock, reset;
   logic csr_wr_en;
   logic [lcalc_pkg::IDX_W-1:0] csr_index;
   logic [lcalc_pkg::REG_W-1:0] csr_wr_data;

   lcalc_req_if req_bus ();
   lcalc_rsp_if rsp_bus ();

   light_sensor_lux_calc_unit dut (
      .clock, .reset, .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_wr_en, .csr_index, .csr_wr_data
   );

   lux_scoreboard_type sb = new();
   bit no_idle;      // last part of the run: no gaps on either side
   int idle_cnt;     // cycles since the last accepted beat

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sink side: random stall bursts on rsp ready, checking every beat.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 11);
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_lux(rsp_bus.lux, rsp_bus.no_calibration);
      end
   end

   // Watchdog: any accepted beat restarts the count.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WATCHDOG) begin
         $display("[light_sensor_lux_calc_unit] ERROR");
         $finish;
      end
   end

   // One beat on the input channel; optional gap first. valid stays high
   // between back-to-back beats.
   task automatic send_counts(logic [lcalc_pkg::CNT_W-1:0] full,
                              logic [lcalc_pkg::CNT_W-1:0] ir);
      int gap;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.full_count <= full;
      req_bus.ir_count   <= ir;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_counts(full, ir);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Register write while idle; the unit then recomputes cpl with ready low.
   // csr_wr_en is then dropped before the task returns, so consecutive writes never overlap.
   task automatic csr_write(lcalc_pkg::reg_idx_type idx, logic [lcalc_pkg::REG_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic random_counts(int n);
      logic [lcalc_pkg::CNT_W-1:0] f, r;
      repeat (n) begin
         case ($urandom_range(0, 4))
            0: begin f = 16'($urandom); r = 16'($urandom); end
            1: begin f = 16'($urandom); r = 16'($urandom_range(0, 255)); end  // mostly visible
            2: begin f = 16'($urandom_range(0, 1023)); r = 16'($urandom_range(0, 1023)); end
            3: begin f = 16'hFFFF; r = 16'($urandom); end
            default: begin f = 16'($urandom); r = f >> $urandom_range(0, 3); end
         endcase
         send_counts(f, r);
      end
   endtask

   // Register sets: {control, atten, scale, devf, b, c, d}.
   task automatic load_setting(logic [lcalc_pkg::CTRL_W-1:0] c, logic [lcalc_pkg::REG_W-1:0] a,
                               logic [lcalc_pkg::REG_W-1:0] s, logic [lcalc_pkg::REG_W-1:0] d,
                               logic [lcalc_pkg::REG_W-1:0] b, logic [lcalc_pkg::REG_W-1:0] cc,
                               logic [lcalc_pkg::REG_W-1:0] dd);
      csr_write(lcalc_pkg::REG_CONTROL, {8'h00, c});
      csr_write(lcalc_pkg::REG_ATTEN, a);
      csr_write(lcalc_pkg::REG_SCALE, s);
      csr_write(lcalc_pkg::REG_DEVF, d);
      csr_write(lcalc_pkg::REG_COEF_B, b);
      csr_write(lcalc_pkg::REG_COEF_C, cc);
      csr_write(lcalc_pkg::REG_COEF_D, dd);
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= '0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.full_count <= '0;
      req_bus.ir_count   <= '0;
      no_idle = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed at reset values: field extremes, IR-dominated (both negative).
      send_counts(16'h0000, 16'h0000);
      send_counts(16'hFFFF, 16'h0000);
      send_counts(16'h0000, 16'hFFFF);
      send_counts(16'hFFFF, 16'hFFFF);
      send_counts(16'hAAAA, 16'h5555);
      send_counts(16'h5555, 16'hAAAA);
      send_counts(16'd1000, 16'd100);
      drain();

      // Time codes 6 and 7, highest gain, zero attenuation treated as one.
      load_setting(8'hF6, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd0);
      send_counts(16'hFFFF, 16'h0000);
      send_counts(16'h1234, 16'hFFFF);
      drain();
      csr_write(lcalc_pkg::REG_CONTROL, 16'h0037);
      send_counts(16'hFFFF, 16'h0001);
      drain();

      // Zero device factor and zero scale: uncalibrated.
      csr_write(lcalc_pkg::REG_DEVF, 16'd0);
      send_counts(16'hFFFF, 16'h0000);
      send_counts(16'h0001, 16'h0002);
      drain();
      csr_write(lcalc_pkg::REG_DEVF, 16'd408);
      csr_write(lcalc_pkg::REG_SCALE, 16'd0);
      send_counts(16'hFFFF, 16'h0000);
      drain();

      // Quotient below one: max attenuation and device factor, least gain.
      load_setting(8'h00, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_counts(16'hFFFF, 16'h0000);
      send_counts(16'h0000, 16'hFFFF);
      drain();

      // Max device factor, coefficient c at max: zero cpl at unit scale, then nonzero cpl and large lux at max scale.
      load_setting(8'h00, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      csr_write(lcalc_pkg::REG_ATTEN, 16'd1);
      send_counts(16'hFFFF, 16'h0000);
      drain();
      csr_write(lcalc_pkg::REG_SCALE, 16'd65535);
      send_counts(16'hFFFF, 16'h0000);
      drain();

      // Random phases, each with a new register setting.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 0)
            load_setting(lcalc_pkg::CTRL_RST, lcalc_pkg::ATTEN_RST, lcalc_pkg::SCALE_RST,
                         lcalc_pkg::DEVF_RST, lcalc_pkg::COEFB_RST, lcalc_pkg::COEFC_RST,
                         lcalc_pkg::COEFD_RST);
         else
            load_setting(lcalc_pkg::CTRL_W'($urandom),
                         lcalc_pkg::REG_W'(($urandom_range(0, 7) == 0) ?
                                           0 : $urandom_range(1, 64)),
                         lcalc_pkg::REG_W'($urandom),
                         lcalc_pkg::REG_W'(($urandom_range(0, 9) == 0) ?
                                           0 : $urandom_range(1, 4000)),
                         lcalc_pkg::REG_W'($urandom), lcalc_pkg::REG_W'($urandom),
                         lcalc_pkg::REG_W'($urandom));
         if (ph == 5) no_idle = 1;
         random_counts(60);
         drain();
      end

      $display("covered %0d result beats (%0d uncalibrated) over reset, extreme and random settings",
               sb.checked, sb.uncal);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[light_sensor_lux_calc_unit] OK");
      else
         $display("[light_sensor_lux_calc_unit] ERROR");
      $finish;
   end
endmodule
